// ----- design/smv_pkg.sv -----
// ----------------------------------------------------------------------------
// smv_pkg: shared types and helpers for the symmetric matrix-vector multiplier
// Opcodes, register indexes, controller/datapath interface and saturation.
// ----------------------------------------------------------------------------
package smv_pkg;

    localparam int MAX_N   = 64;
    localparam int IDX_W   = $clog2(MAX_N);
    localparam int DIM_W   = IDX_W + 1;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_LOAD_MATRIX = 2'd0,
        OP_LOAD_X      = 2'd1,
        OP_LOAD_Y      = 2'd2,
        OP_RUN         = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_REVERSED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_REVERSED = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             acc_clear;
        logic             y_read;
        logic             issue;
        logic             scale;
        logic             finish;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } smv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             pipe_busy;
        logic [DIM_W-1:0] dim;
    } smv_status_t;

    // Saturate a 49-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sh0_0000_7FFF_FFFF;
        lo = -49'sh0_0000_8000_0000;
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/smv_datapath.sv -----
// ----------------------------------------------------------------------------
// smv_datapath: stores, configuration and multiply-accumulate datapath
// Holds the matrix, x and y memories and the Q16.16 arithmetic pipeline.
// ----------------------------------------------------------------------------
module smv_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_accept,
    input  logic [1:0]                   opcode,
    input  logic [smv_pkg::IDX_W-1:0]    first_index,
    input  logic [smv_pkg::IDX_W-1:0]    second_index,
    input  logic signed [31:0]           value,
    input  logic                         cfg_write_enable,
    input  logic [smv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  smv_pkg::smv_cmd_t            cmd,
    output smv_pkg::smv_status_t         status,
    output logic [smv_pkg::IDX_W-1:0]    position,
    output logic signed [31:0]           result,
    output logic                         last
);
    import smv_pkg::*;

    logic [DIM_W-1:0]   dimension_reg;
    logic               use_upper_reg;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic               x_rev_reg;
    logic               y_rev_reg;

    logic [DATA_W-1:0]  matrix_mem [MAX_N*MAX_N];
    logic [DATA_W-1:0]  x_mem [MAX_N];
    logic [DATA_W-1:0]  y_mem [MAX_N];

    logic signed [31:0] a_rd_reg;
    logic signed [31:0] x_rd_reg;
    logic signed [31:0] y_rd_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] alpha_prod_reg;
    logic signed [63:0] beta_prod_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic [IDX_W-1:0]   position_reg;
    logic signed [31:0] result_reg;
    logic               last_reg;

    logic [DIM_W-1:0]   dim;
    logic               direct;
    logic [2*IDX_W-1:0] a_addr;
    logic [IDX_W-1:0]   x_addr;
    logic [IDX_W-1:0]   y_pos;
    logic [DIM_W-1:0]   x_rev_pos;
    logic [DIM_W-1:0]   y_rev_pos;
    logic signed [48:0] acc_sum;
    logic signed [48:0] final_sum;
    logic signed [31:0] final_val;
    logic               y_we;
    logic [IDX_W-1:0]   y_waddr;
    logic [DATA_W-1:0]  y_wdata;

    always_comb
    begin
        if (dimension_reg == '0)
        begin
            dim = DIM_W'(1);
        end
        else if (dimension_reg > DIM_W'(MAX_N))
        begin
            dim = DIM_W'(MAX_N);
        end
        else
        begin
            dim = dimension_reg;
        end
    end

    assign direct    = use_upper_reg ? (cmd.row <= cmd.col) : (cmd.row >= cmd.col);
    // Element (r,c) lives at r + c*MAX_N.
    assign a_addr    = direct ? {cmd.col, cmd.row} : {cmd.row, cmd.col};
    assign x_rev_pos = dim - DIM_W'(1) - {1'b0, cmd.col};
    assign y_rev_pos = dim - DIM_W'(1) - {1'b0, cmd.row};
    assign x_addr    = x_rev_reg ? x_rev_pos[IDX_W-1:0] : cmd.col;
    assign y_pos     = y_rev_reg ? y_rev_pos[IDX_W-1:0] : cmd.row;

    assign acc_sum   = {{17{acc_reg[31]}}, acc_reg} + {prod_reg[63], prod_reg[63:16]};
    assign final_sum = {alpha_prod_reg[63], alpha_prod_reg[63:16]}
                     + {beta_prod_reg[63], beta_prod_reg[63:16]};
    assign final_val = sat32(final_sum);

    // One write port on y: loads when idle, write-back during a run.
    assign y_we    = cmd.finish || (in_accept && opcode == OP_LOAD_Y);
    assign y_waddr = cmd.finish ? y_pos : first_index;
    assign y_wdata = cmd.finish ? final_val : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_W'(MAX_N);
            use_upper_reg <= 1'b1;
            alpha_reg     <= 32'sd65536;
            beta_reg      <= '0;
            x_rev_reg     <= 1'b0;
            y_rev_reg     <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_DIMENSION:  dimension_reg <= cfg_data[DIM_W-1:0];
                REG_USE_UPPER:  use_upper_reg <= cfg_data[0];
                REG_ALPHA_GAIN: alpha_reg     <= cfg_data;
                REG_BETA_GAIN:  beta_reg      <= cfg_data;
                REG_X_REVERSED: x_rev_reg     <= cfg_data[0];
                REG_Y_REVERSED: y_rev_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == OP_LOAD_MATRIX)
        begin
            matrix_mem[{second_index, first_index}] <= value;
        end
        if (cmd.issue)
        begin
            a_rd_reg <= matrix_mem[a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == OP_LOAD_X)
        begin
            x_mem[first_index] <= value;
        end
        if (cmd.issue)
        begin
            x_rd_reg <= x_mem[x_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (cmd.y_read)
        begin
            y_rd_reg <= y_mem[y_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= sat32(acc_sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= a_rd_reg * x_rd_reg;
        end
        if (cmd.scale)
        begin
            alpha_prod_reg <= alpha_reg * acc_reg;
            beta_prod_reg  <= beta_reg * y_rd_reg;
        end
        if (cmd.finish)
        begin
            position_reg <= y_pos;
            result_reg   <= final_val;
            last_reg     <= cmd.last;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.dim       = dim;
    assign position         = position_reg;
    assign result           = result_reg;
    assign last             = last_reg;

endmodule

// ----- design/smv_controller.sv -----
// ----------------------------------------------------------------------------
// smv_controller: run sequencer
// Walks rows and columns of a run and hands each result word to the output.
// ----------------------------------------------------------------------------
module smv_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             opcode,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output smv_pkg::smv_cmd_t      cmd,
    input  smv_pkg::smv_status_t   status
);
    import smv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_FINAL,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic             out_valid_reg;
    logic             last_row;
    logic             last_col;

    assign last_row = ({1'b0, row_reg} == status.dim - DIM_W'(1));
    assign last_col = ({1'b0, col_reg} == status.dim - DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && opcode == OP_RUN)
                    begin
                        row_reg   <= '0;
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    col_reg   <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    col_reg <= col_reg + IDX_W'(1);
                    if (last_col)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!status.pipe_busy)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_FINAL;
                end
                ST_FINAL:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_row)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + IDX_W'(1);
                            state_reg <= ST_ROW;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign cmd.acc_clear = (state_reg == ST_ROW);
    assign cmd.y_read    = (state_reg == ST_ROW);
    assign cmd.issue     = (state_reg == ST_MAC);
    assign cmd.scale     = (state_reg == ST_SCALE);
    assign cmd.finish    = (state_reg == ST_FINAL);
    assign cmd.last      = last_row;
    assign cmd.row       = row_reg;
    assign cmd.col       = col_reg;

    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT))
        else $error("result word valid outside the emit state");

    a_busy_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result word is pending");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ({1'b0, col_reg} < status.dim))
        else $error("column counter beyond the matrix order");

    a_pipe_empty_at_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> !status.pipe_busy)
        else $error("scaling started before the accumulation finished");

endmodule

// ----- design/symmetric_matrix_vector_multiply_top.sv -----
// ----------------------------------------------------------------------------
// symmetric_matrix_vector_multiply_top: y = alpha*A*x + beta*y in Q16.16
// Top level joining the run controller and the storage/arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage: input words carry an opcode. Load words (matrix entry, x or y
// element) are taken one per cycle while the block is idle and produce no
// output. A run word starts the computation for the configured order n and
// emits n result words, one per row, the last one flagged by last. Each
// result is also written back into the y store.
// The time of a row is dominated by the single matrix memory read port
// that delivers one entry per cycle, followed by a three-stage
// read/multiply/accumulate pipeline that drains before scaling, one
// scaling stage and one output stage.
// The input side is stalled for the whole run. When the receiver stalls, the
// result word is held in the output register and the run waits.
// Reset (asynchronous, active low) returns to idle, clears the accumulator
// and sets the registers to their defaults. The matrix, x and y stores are
// not cleared and must be loaded before they are read.
// Configuration may only be written while no run is in progress.
// ----------------------------------------------------------------------------
module symmetric_matrix_vector_multiply_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [smv_pkg::IDX_W-1:0]     first_index,
    input  logic [smv_pkg::IDX_W-1:0]     second_index,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [smv_pkg::IDX_W-1:0]     position,
    output logic signed [31:0]            result,
    output logic                          last,
    input  logic                          cfg_write_enable,
    input  logic [smv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import smv_pkg::*;

    smv_cmd_t    cmd;
    smv_status_t status;
    logic        in_accept;

    // A word is taken whenever valid is high and the block is not stalling.
    assign in_accept = in_valid && !in_stall;

    smv_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    smv_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_accept        (in_accept),
        .opcode           (opcode),
        .first_index      (first_index),
        .second_index     (second_index),
        .value            (value),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .position         (position),
        .result           (result),
        .last             (last)
    );

endmodule

// ----- dv/symmetric_matrix_vector_multiply_top_test.sv -----
// ----------------------------------------------------------------------------
// symmetric_matrix_vector_multiply_top_test: self-checking bench for y = aAx+by
// Loads matrix entries, x and y elements, issues runs under many register
// settings, and checks every result word against an in-bench predictor.
// ----------------------------------------------------------------------------
module symmetric_matrix_vector_multiply_top_test;

    import smv_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct {
        logic [IDX_W-1:0]   pos;
        logic signed [31:0] value;
        bit                 last;
    } y_word_t;

    // The scoreboard mirrors the stores and registers of the block. Every
    // accepted input word updates the mirror, and a run word pushes the
    // expected y words of all rows in order.
    class symv_scoreboard;
        logic signed [31:0] matrix_mem [MAX_N*MAX_N];
        bit                 matrix_set [MAX_N*MAX_N];
        logic signed [31:0] x_mem [MAX_N];
        bit                 x_set [MAX_N];
        logic signed [31:0] y_mem [MAX_N];
        bit                 y_set [MAX_N];
        logic [DIM_W-1:0]   dimension = 7'd64;
        bit                 use_upper = 1'b1;
        logic signed [31:0] alpha = 32'sd65536;
        logic signed [31:0] beta = 32'sd0;
        bit                 x_rev = 1'b0;
        bit                 y_rev = 1'b0;
        y_word_t            pending_rows [$];
        int                 failures = 0;

        function int order();
            if (dimension < 1)
            begin
                return 1;
            end
            if (dimension > MAX_N)
            begin
                return MAX_N;
            end
            return int'(dimension);
        endfunction

        // Address of the stored element that supplies element (r,c).
        function int entry_addr(int r, int c);
            bit direct;
            direct = use_upper ? (r <= c) : (r >= c);
            return direct ? (r + c*MAX_N) : (c + r*MAX_N);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_DIMENSION:  dimension = data[DIM_W-1:0];
                REG_USE_UPPER:  use_upper = data[0];
                REG_ALPHA_GAIN: alpha = data;
                REG_BETA_GAIN:  beta = data;
                REG_X_REVERSED: x_rev = data[0];
                REG_Y_REVERSED: y_rev = data[0];
                default: ;
            endcase
        endfunction

        function void predict_run();
            int     n;
            int     xp;
            int     yp;
            longint acc;
            longint prod;
            longint total;
            y_word_t w;
            n = order();
            for (int r = 0; r < n; r++)
            begin
                acc = 0;
                for (int c = 0; c < n; c++)
                begin
                    xp = x_rev ? (n - 1 - c) : c;
                    prod = longint'(matrix_mem[entry_addr(r, c)]) * longint'(x_mem[xp]);
                    acc = clamp32(acc + (prod >>> 16));
                end
                yp = y_rev ? (n - 1 - r) : r;
                total = clamp32(((longint'(alpha) * acc) >>> 16) +
                                ((longint'(beta) * longint'(y_mem[yp])) >>> 16));
                y_mem[yp] = total[31:0];
                y_set[yp] = 1'b1;
                w.pos = yp[IDX_W-1:0];
                w.value = total[31:0];
                w.last = (r == n - 1);
                pending_rows.push_back(w);
            end
        endfunction

        function void note_word(opcode_t op, logic [IDX_W-1:0] i1, logic [IDX_W-1:0] i2,
                                logic signed [31:0] v);
            case (op)
                OP_LOAD_MATRIX:
                begin
                    matrix_mem[i1 + i2*MAX_N] = v;
                    matrix_set[i1 + i2*MAX_N] = 1'b1;
                end
                OP_LOAD_X:
                begin
                    x_mem[i1] = v;
                    x_set[i1] = 1'b1;
                end
                OP_LOAD_Y:
                begin
                    y_mem[i1] = v;
                    y_set[i1] = 1'b1;
                end
                default: predict_run();
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            failures++;
        endtask

        task check_result(logic [IDX_W-1:0] pos, logic signed [31:0] value, logic lst);
            y_word_t w;
            if (pending_rows.size() == 0)
            begin
                report($sformatf("unexpected y word pos=%0d value=%h", pos, value));
            end
            else
            begin
                w = pending_rows.pop_front();
                if (pos !== w.pos)
                begin
                    report($sformatf("position %0d, expected %0d", pos, w.pos));
                end
                if (value !== w.value)
                begin
                    report($sformatf("result %h at position %0d, expected %h",
                                     value, w.pos, w.value));
                end
                if (lst !== w.last)
                begin
                    report($sformatf("last %b at position %0d, expected %b",
                                     lst, w.pos, w.last));
                end
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             opcode = 2'd0;
    logic [IDX_W-1:0]       first_index = '0;
    logic [IDX_W-1:0]       second_index = '0;
    logic signed [31:0]     value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic [IDX_W-1:0]       position;
    logic signed [31:0]     result;
    logic                   last;
    logic                   cfg_write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    symv_scoreboard sb = new();
    int words_sent = 0;
    int stuck_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_outputs = 1'b0;

    symmetric_matrix_vector_multiply_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .first_index      (first_index),
        .second_index     (second_index),
        .value            (value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .position         (position),
        .result           (result),
        .last             (last),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // Every result word accepted by the receiver is checked in order. Inputs
    // are driven with nonblocking assignments, so the values read here are the
    // ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(position, result, last);
        end
    end

    // The watchdog ends the simulation when nothing has made progress for too long. Its
    // limit covers the long receiver hold plus a full row.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            cfg_write_enable)
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // The receiver draws a stall length for every word. Once the main
    // sequence asks for it, it holds off for a long stretch so that the
    // block backs up and stalls its input.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_outputs)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_outputs = 1'b0;
            end
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    function logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    // Offers one word after a random gap and waits until it is taken. The
    // valid stays high when the next word follows with no gap.
    task send_word(opcode_t op, int i1, int i2, logic signed [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode <= op;
        first_index <= i1[IDX_W-1:0];
        second_index <= i2[IDX_W-1:0];
        value <= v;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_word(op, i1[IDX_W-1:0], i2[IDX_W-1:0], v);
        words_sent++;
    endtask

    // Registers change only once every expected word is out and the block
    // has had time to drain.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task set_order(int dim, bit upper, logic [31:0] a, logic [31:0] b, bit xr, bit yr);
        write_reg(REG_DIMENSION, {$urandom} << DIM_W | dim[DIM_W-1:0]);
        write_reg(REG_USE_UPPER, {$urandom} << 1 | upper);
        write_reg(REG_ALPHA_GAIN, a);
        write_reg(REG_BETA_GAIN, b);
        write_reg(REG_X_REVERSED, {$urandom} << 1 | xr);
        write_reg(REG_Y_REVERSED, {$urandom} << 1 | yr);
    endtask

    // Some random loads, then every element the run will read is loaded if it
    // has never been written, then the run word itself.
    task run_sequence(int noise);
        int n;
        int a;
        n = sb.order();
        repeat (noise)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(opcode_t'($urandom_range(0, 2)), $urandom_range(0, MAX_N - 1),
                          $urandom_range(0, MAX_N - 1), pick_value());
            end
            else
            begin
                send_word(opcode_t'($urandom_range(0, 2)), $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1), pick_value());
            end
        end
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                a = sb.entry_addr(r, c);
                if (!sb.matrix_set[a])
                begin
                    send_word(OP_LOAD_MATRIX, a % MAX_N, a / MAX_N, pick_value());
                end
            end
            if (!sb.x_set[r])
            begin
                send_word(OP_LOAD_X, r, $urandom_range(0, MAX_N - 1), pick_value());
            end
            if (!sb.y_set[r])
            begin
                send_word(OP_LOAD_Y, r, $urandom_range(0, MAX_N - 1), pick_value());
            end
        end
        send_word(OP_RUN, $urandom_range(0, MAX_N - 1), $urandom_range(0, MAX_N - 1),
                  $urandom);
    endtask

    function logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    initial
    begin
        int dim;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes for every load opcode, then a run at dimension zero,
        // which the block treats as order one.
        send_word(OP_LOAD_MATRIX, 0, 0, 32'sh7FFF_FFFF);
        send_word(OP_LOAD_MATRIX, MAX_N - 1, MAX_N - 1, 32'sh8000_0000);
        send_word(OP_LOAD_X, MAX_N - 1, MAX_N - 1, 32'sh8000_0000);
        send_word(OP_LOAD_X, 0, 0, 32'sh7FFF_FFFF);
        send_word(OP_LOAD_Y, MAX_N - 1, 0, 32'sh7FFF_FFFF);
        send_word(OP_LOAD_Y, 0, MAX_N - 1, 32'sh8000_0000);
        set_order(0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        send_word(OP_RUN, MAX_N - 1, MAX_N - 1, 32'shFFFF_FFFF);

        // Small order with the lower triangle, both vectors reversed and
        // gains at the opposite extremes. Indexes past the register list are
        // written too; the block must ignore them.
        set_order(3, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        run_sequence(4);

        // A larger order with no gaps on either side: the upper triangle is
        // read first, then the lower one.
        no_gaps = 1'b1;
        set_order(12, 1'b1, 32'h0001_0000, 32'h0000_8000, 1'b0, 1'b1);
        run_sequence(0);
        set_order(12, 1'b0, 32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b0);
        run_sequence(0);
        no_gaps = 1'b0;

        // The receiver holds off while the sender keeps offering words behind
        // a run, so the block fills up and stalls its input.
        set_order(8, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0);
        hold_outputs = 1'b1;
        run_sequence(2);
        repeat (10)
        begin
            send_word(opcode_t'($urandom_range(0, 2)), $urandom_range(0, MAX_N - 1),
                      $urandom_range(0, MAX_N - 1), pick_value());
        end

        // Random phases, mostly small orders with random content.
        while (words_sent < 400)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: dim = 0;
                1: dim = $urandom_range(9, 12);
                2: dim = $urandom_range(9, 16);
                default: dim = $urandom_range(1, 8);
            endcase
            set_order(dim, $urandom_range(0, 1), pick_gain(), pick_gain(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) run_sequence($urandom_range(0, 12));
        end

        in_valid <= 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
